>>> rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared types, constants and functions of the complex ALU
// Fixed-point format, operation codes, divider lane record, saturation.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int DW2    = 2 * DATA_WIDTH;           // product width
	localparam int ACC_W  = DW2 + 1;                  // exact sum of two products
	localparam int NUM_W  = ACC_W + FRAC_BITS;        // scaled dividend
	localparam int CMP_W  = NUM_W + DATA_WIDTH;       // quotient range check
	localparam int IN_TDATA_W  = ((4 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// one divider lane: partial remainder, unused dividend bits, quotient so far
	typedef struct packed {
		logic [DW2-1:0]        rem;
		logic [DATA_WIDTH-1:0] nlo;
		logic [DATA_WIDTH-1:0] quo;
		logic                  neg;
		logic                  big;   // quotient >= 2^DATA_WIDTH
	} div_lane_t;

	// result of the non-divide paths plus flags, rides along the divider
	typedef struct packed {
		logic                  is_div;
		logic                  dz;
		logic                  ovf;
		logic [DATA_WIDTH-1:0] re;
		logic [DATA_WIDTH-1:0] im;
	} res_ctl_t;

	typedef struct packed {
		logic                  ovf;
		logic [DATA_WIDTH-1:0] val;
	} sat_t;

	// sign/magnitude to saturated two's complement
	function automatic sat_t sat_fn(logic [ACC_W-1:0] mag, logic neg);
		logic [ACC_W-1:0] lim;
		sat_t r;
		lim = ACC_W'(1) << (DATA_WIDTH - 1);
		r.ovf = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				r.ovf = 1'b1;
				r.val = SAT_MIN;
			end else begin
				r.val = DATA_WIDTH'(ACC_W'(0) - mag);
			end
		end else begin
			if (mag > lim - ACC_W'(1)) begin
				r.ovf = 1'b1;
				r.val = SAT_MAX;
			end else begin
				r.val = mag[DATA_WIDTH-1:0];
			end
		end
		return r;
	endfunction

	// one restoring division step: one quotient bit
	function automatic div_lane_t div_step(div_lane_t l, logic [DW2-1:0] den);
		logic [DW2:0] t;
		div_lane_t r;
		r = l;
		t = {l.rem, l.nlo[DATA_WIDTH-1]};
		r.nlo = {l.nlo[DATA_WIDTH-2:0], 1'b0};
		if (t >= {1'b0, den}) begin
			r.rem = DW2'(t - {1'b0, den});
			r.quo = {l.quo[DATA_WIDTH-2:0], 1'b1};
		end else begin
			r.rem = t[DW2-1:0];
			r.quo = {l.quo[DATA_WIDTH-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

>>> rtl/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: operand capture, products, sums
// s1 input register, s2 six signed products, s3 exact real/imag sums and |b|^2.
// ----------------------------------------------------------------------------
module cau_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [1:0]                           operation,
	input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
	input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
	input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
	input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
	output logic                                 v_s3,
	output logic [1:0]                           op_s3,
	output logic signed [cau_pkg::ACC_W-1:0]      acc_re_s3,
	output logic signed [cau_pkg::ACC_W-1:0]      acc_im_s3,
	output logic [cau_pkg::DW2-1:0]              den_s3
);

	logic                                  v_s1, v_s2;
	logic [1:0]                            op_s1, op_s2;
	logic signed [cau_pkg::DATA_WIDTH-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [cau_pkg::DATA_WIDTH-1:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [cau_pkg::DW2-1:0]        rr_s2, ii_s2, ri_s2, ir_s2, sqr_s2, sqi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= operation;
			ar_s1 <= a_re;
			ai_s1 <= a_im;
			br_s1 <= b_re;
			bi_s1 <= b_im;

			op_s2  <= op_s1;
			ar_s2  <= ar_s1;
			ai_s2  <= ai_s1;
			br_s2  <= br_s1;
			bi_s2  <= bi_s1;
			rr_s2  <= ar_s1 * br_s1;
			ii_s2  <= ai_s1 * bi_s1;
			ri_s2  <= ar_s1 * bi_s1;
			ir_s2  <= ai_s1 * br_s1;
			sqr_s2 <= br_s1 * br_s1;
			sqi_s2 <= bi_s1 * bi_s1;

			op_s3  <= op_s2;
			den_s3 <= cau_pkg::DW2'(sqr_s2) + cau_pkg::DW2'(sqi_s2);
			unique case (op_s2)
				cau_pkg::OP_ADD: begin
					acc_re_s3 <= cau_pkg::ACC_W'(ar_s2) + cau_pkg::ACC_W'(br_s2);
					acc_im_s3 <= cau_pkg::ACC_W'(ai_s2) + cau_pkg::ACC_W'(bi_s2);
				end
				cau_pkg::OP_SUB: begin
					acc_re_s3 <= cau_pkg::ACC_W'(ar_s2) - cau_pkg::ACC_W'(br_s2);
					acc_im_s3 <= cau_pkg::ACC_W'(ai_s2) - cau_pkg::ACC_W'(bi_s2);
				end
				cau_pkg::OP_MUL: begin
					acc_re_s3 <= cau_pkg::ACC_W'(rr_s2) - cau_pkg::ACC_W'(ii_s2);
					acc_im_s3 <= cau_pkg::ACC_W'(ri_s2) + cau_pkg::ACC_W'(ir_s2);
				end
				default: begin
					acc_re_s3 <= cau_pkg::ACC_W'(rr_s2) + cau_pkg::ACC_W'(ii_s2);
					acc_im_s3 <= cau_pkg::ACC_W'(ir_s2) - cau_pkg::ACC_W'(ri_s2);
				end
			endcase
		end
	end

endmodule

>>> rtl/cau_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step: one registered divider stage
// Retires one quotient bit for both the real and imaginary lanes.
// ----------------------------------------------------------------------------
module cau_div_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_in,
	input  logic [cau_pkg::DW2-1:0]   den_in,
	input  cau_pkg::res_ctl_t         ctl_in,
	input  cau_pkg::div_lane_t        lre_in,
	input  cau_pkg::div_lane_t        lim_in,
	output logic                      v_out,
	output logic [cau_pkg::DW2-1:0]   den_out,
	output cau_pkg::res_ctl_t         ctl_out,
	output cau_pkg::div_lane_t        lre_out,
	output cau_pkg::div_lane_t        lim_out
);

	logic                    v_s1;
	logic [cau_pkg::DW2-1:0] den_s1;
	cau_pkg::res_ctl_t       ctl_s1;
	cau_pkg::div_lane_t      lre_s1, lim_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1 <= den_in;
			ctl_s1 <= ctl_in;
			lre_s1 <= cau_pkg::div_step(lre_in, den_in);
			lim_s1 <= cau_pkg::div_step(lim_in, den_in);
		end
	end

	assign v_out   = v_s1;
	assign den_out = den_s1;
	assign ctl_out = ctl_s1;
	assign lre_out = lre_s1;
	assign lim_out = lim_s1;

endmodule

>>> rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add/sub/mul/div, Q16.16
// Streaming complex ALU with saturation and divide-by-zero flagging.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one
// result beat per input beat, in order. Every operation passes through the
// same stages: capture, multiply and sum, sign and magnitude, divider setup,
// one divider step per quotient bit, and the output register. Add, subtract
// and multiply ride along the divider chain so results never reorder. A
// stall from the output side freezes the whole pipe; s_tready is low only
// while a result beat is held and m_tready is low. Multiply truncates toward
// zero after dropping the fraction bits; divide computes (a * conj(b)) /
// |b|^2 exactly and truncates toward zero. A zero divisor returns 0 with
// div_by_zero set. Any part out of range saturates and sets overflow.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// a_re, a_im, b_re, b_im (lowest first), zero padded
	input  logic [cau_pkg::IN_TDATA_W-1:0]       s_tdata,
	// operation
	input  logic [1:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// res_re, res_im (lowest first), zero padded
	output logic [cau_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// div_by_zero, overflow (lowest first)
	output logic [1:0]                           m_tuser
);

	localparam int W = cau_pkg::DATA_WIDTH;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- s1..s3: products and sums
	logic                             v_s3;
	logic [1:0]                       op_s3;
	logic signed [cau_pkg::ACC_W-1:0] acc_re_s3, acc_im_s3;
	logic [cau_pkg::DW2-1:0]          den_s3;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.operation (s_tuser),
		.a_re      ($signed(s_tdata[W-1:0])),
		.a_im      ($signed(s_tdata[2*W-1:W])),
		.b_re      ($signed(s_tdata[3*W-1:2*W])),
		.b_im      ($signed(s_tdata[4*W-1:3*W])),
		.v_s3      (v_s3),
		.op_s3     (op_s3),
		.acc_re_s3 (acc_re_s3),
		.acc_im_s3 (acc_im_s3),
		.den_s3    (den_s3)
	);

	// ---------------- s4: sign and magnitude
	logic                       v_s4;
	logic [1:0]                 op_s4;
	logic                       neg_re_s4, neg_im_s4;
	logic [cau_pkg::ACC_W-1:0]  mag_re_s4, mag_im_s4;
	logic [cau_pkg::DW2-1:0]    den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4     <= op_s3;
			den_s4    <= den_s3;
			neg_re_s4 <= acc_re_s3[cau_pkg::ACC_W-1];
			neg_im_s4 <= acc_im_s3[cau_pkg::ACC_W-1];
			mag_re_s4 <= acc_re_s3[cau_pkg::ACC_W-1] ? cau_pkg::ACC_W'(-acc_re_s3)
			                                           : cau_pkg::ACC_W'(acc_re_s3);
			mag_im_s4 <= acc_im_s3[cau_pkg::ACC_W-1] ? cau_pkg::ACC_W'(-acc_im_s3)
			                                           : cau_pkg::ACC_W'(acc_im_s3);
		end
	end

	// ---------------- s5: finish add/sub/mul, set up divider lanes
	logic [cau_pkg::ACC_W-1:0] scl_re, scl_im;
	cau_pkg::sat_t             sat_re, sat_im;
	logic [cau_pkg::NUM_W-1:0] num_re, num_im;
	logic [cau_pkg::CMP_W-1:0] den_top;
	cau_pkg::res_ctl_t         ctl_d;
	cau_pkg::div_lane_t        lre_d, lim_d;

	always_comb begin
		if (op_s4 == cau_pkg::OP_MUL) begin
			scl_re = mag_re_s4 >> cau_pkg::FRAC_BITS;
			scl_im = mag_im_s4 >> cau_pkg::FRAC_BITS;
		end else begin
			scl_re = mag_re_s4;
			scl_im = mag_im_s4;
		end
		sat_re = cau_pkg::sat_fn(scl_re, neg_re_s4);
		sat_im = cau_pkg::sat_fn(scl_im, neg_im_s4);

		ctl_d.is_div = (op_s4 == cau_pkg::OP_DIV);
		ctl_d.dz     = (den_s4 == '0);
		ctl_d.ovf    = sat_re.ovf || sat_im.ovf;
		ctl_d.re     = sat_re.val;
		ctl_d.im     = sat_im.val;

		num_re  = cau_pkg::NUM_W'(mag_re_s4) << cau_pkg::FRAC_BITS;
		num_im  = cau_pkg::NUM_W'(mag_im_s4) << cau_pkg::FRAC_BITS;
		den_top = cau_pkg::CMP_W'(den_s4) << W;

		lre_d.rem = cau_pkg::DW2'(num_re >> W);
		lre_d.nlo = num_re[W-1:0];
		lre_d.quo = '0;
		lre_d.neg = neg_re_s4;
		lre_d.big = (cau_pkg::CMP_W'(num_re) >= den_top);
		lim_d.rem = cau_pkg::DW2'(num_im >> W);
		lim_d.nlo = num_im[W-1:0];
		lim_d.quo = '0;
		lim_d.neg = neg_im_s4;
		lim_d.big = (cau_pkg::CMP_W'(num_im) >= den_top);
	end

	// divider chain: position 0 is s5, position W is the last step
	logic                    v_c   [0:W];
	logic [cau_pkg::DW2-1:0] den_c [0:W];
	cau_pkg::res_ctl_t       ctl_c [0:W];
	cau_pkg::div_lane_t      lre_c [0:W];
	cau_pkg::div_lane_t      lim_c [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[0] <= 1'b0;
		end else if (en) begin
			v_c[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_c[0] <= den_s4;
			ctl_c[0] <= ctl_d;
			lre_c[0] <= lre_d;
			lim_c[0] <= lim_d;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < W; gi++) begin : g_div
			cau_div_step u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.v_in    (v_c[gi]),
				.den_in  (den_c[gi]),
				.ctl_in  (ctl_c[gi]),
				.lre_in  (lre_c[gi]),
				.lim_in  (lim_c[gi]),
				.v_out   (v_c[gi+1]),
				.den_out (den_c[gi+1]),
				.ctl_out (ctl_c[gi+1]),
				.lre_out (lre_c[gi+1]),
				.lim_out (lim_c[gi+1])
			);
		end
	endgenerate

	// ---------------- output stage: divide result select and saturate
	cau_pkg::res_ctl_t  ctl_e;
	cau_pkg::div_lane_t lre_e, lim_e;
	cau_pkg::sat_t      qs_re, qs_im;
	logic [W-1:0]       fin_re, fin_im;
	logic               fin_dz, fin_ovf;

	always_comb begin
		ctl_e = ctl_c[W];
		lre_e = lre_c[W];
		lim_e = lim_c[W];
		qs_re = cau_pkg::sat_fn(cau_pkg::ACC_W'(lre_e.quo), lre_e.neg);
		qs_im = cau_pkg::sat_fn(cau_pkg::ACC_W'(lim_e.quo), lim_e.neg);
		if (lre_e.big) begin
			qs_re.ovf = 1'b1;
			qs_re.val = lre_e.neg ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
		end
		if (lim_e.big) begin
			qs_im.ovf = 1'b1;
			qs_im.val = lim_e.neg ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
		end
		if (!ctl_e.is_div) begin
			fin_re  = ctl_e.re;
			fin_im  = ctl_e.im;
			fin_dz  = 1'b0;
			fin_ovf = ctl_e.ovf;
		end else if (ctl_e.dz) begin
			fin_re  = '0;
			fin_im  = '0;
			fin_dz  = 1'b1;
			fin_ovf = 1'b0;
		end else begin
			fin_re  = qs_re.val;
			fin_im  = qs_im.val;
			fin_dz  = 1'b0;
			fin_ovf = qs_re.ovf || qs_im.ovf;
		end
	end

	logic         out_v_q;
	logic [W-1:0] res_re_q, res_im_q;
	logic         dz_q, ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_c[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= fin_re;
			res_im_q <= fin_im;
			dz_q     <= fin_dz;
			ovf_q    <= fin_ovf;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = cau_pkg::OUT_TDATA_W'({res_im_q, res_re_q});
	assign m_tuser  = {ovf_q, dz_q};

	// ---------------- checks
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dz_q |-> (res_re_q == '0) && (res_im_q == '0) && !ovf_q)
		else $error("divide-by-zero result not clean");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> u_front.v_s1)
		else $error("accepted beat missing from first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(v_c[W]) && $stable(ctl_c[W]))
		else $error("divider chain moved during stall");

endmodule

>>> tb/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit: self-checking regression for the complex ALU
// Directed corner beats and phased random traffic with sender and receiver
// throttling. Each accepted beat is predicted with wide signed math and every
// result beat is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;

	localparam int LIMIT_CYCLES = 600000;
	localparam int TAIL_CYCLES  = 60;     // pipe is DATA_WIDTH + 6 deep

	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		logic [cau_pkg::DATA_WIDTH-1:0] re;
		logic [cau_pkg::DATA_WIDTH-1:0] im;
		logic                           dz;
		logic                           ovf;
	} cplx_res_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [cau_pkg::IN_TDATA_W-1:0] s_tdata;  // a_re, a_im, b_re, b_im
	logic [1:0] s_tuser;                      // operation
	logic m_tvalid;
	logic m_tready;
	logic [cau_pkg::OUT_TDATA_W-1:0] m_tdata; // res_re, res_im
	logic [1:0] m_tuser;                      // div_by_zero, overflow

	cplx_res_t pending_res[$];
	int errors;
	int beats_in;
	int beats_out;
	int div_zero_seen;
	int ovf_seen;
	int idle_pct;
	int stall_pct;
	int cycles;

	complex_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clamp to the data width, flag when clamped
	function automatic logic [cau_pkg::DATA_WIDTH-1:0] clamp(wide_t v, inout logic ovf);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (cau_pkg::DATA_WIDTH - 1)) - 1;
		lo = -(wide_t'(1) <<< (cau_pkg::DATA_WIDTH - 1));
		if (v > hi) begin
			ovf = 1'b1;
			return cau_pkg::SAT_MAX;
		end
		if (v < lo) begin
			ovf = 1'b1;
			return cau_pkg::SAT_MIN;
		end
		return v[cau_pkg::DATA_WIDTH-1:0];
	endfunction

	function automatic cplx_res_t alu_predict(logic [1:0] op,
			logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
			logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
			logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
			logic signed [cau_pkg::DATA_WIDTH-1:0] b_im);
		wide_t ar, ai, br, bi, re, im, mag2, scale;
		cplx_res_t r;
		ar = a_re;
		ai = a_im;
		br = b_re;
		bi = b_im;
		scale = wide_t'(1) <<< cau_pkg::FRAC_BITS;
		r.dz = 1'b0;
		r.ovf = 1'b0;
		case (op)
			cau_pkg::OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			cau_pkg::OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			cau_pkg::OP_MUL: begin
				// signed division truncates toward zero
				re = (ar * br - ai * bi) / scale;
				im = (ar * bi + br * ai) / scale;
			end
			default: begin
				mag2 = br * br + bi * bi;
				if (mag2 == 0) begin
					r.dz = 1'b1;
					re = 0;
					im = 0;
				end else begin
					re = ((ar * br + ai * bi) * scale) / mag2;
					im = ((ai * br - ar * bi) * scale) / mag2;
				end
			end
		endcase
		r.re = clamp(re, r.ovf);
		r.im = clamp(im, r.ovf);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [cau_pkg::DATA_WIDTH-1:0] got,
			logic [cau_pkg::DATA_WIDTH-1:0] want);
		errors++;
		$display("MISMATCH beat %0d %s: got %h want %h", beats_out, what, got, want);
	endtask

	// result side: throttle and check
	always @(posedge clk) begin
		cplx_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				errors++;
				$display("MISMATCH unexpected result beat %0d", beats_out);
			end else begin
				want = pending_res.pop_front();
				if (m_tdata[cau_pkg::DATA_WIDTH-1:0] !== want.re)
					report_mismatch("res_re", m_tdata[cau_pkg::DATA_WIDTH-1:0], want.re);
				if (m_tdata[2*cau_pkg::DATA_WIDTH-1:cau_pkg::DATA_WIDTH] !== want.im)
					report_mismatch("res_im",
						m_tdata[2*cau_pkg::DATA_WIDTH-1:cau_pkg::DATA_WIDTH], want.im);
				if (m_tuser[0] !== want.dz)
					report_mismatch("div_by_zero", cau_pkg::DATA_WIDTH'(m_tuser[0]),
						cau_pkg::DATA_WIDTH'(want.dz));
				if (m_tuser[1] !== want.ovf)
					report_mismatch("overflow", cau_pkg::DATA_WIDTH'(m_tuser[1]),
						cau_pkg::DATA_WIDTH'(want.ovf));
				div_zero_seen += want.dz;
				ovf_seen += want.ovf;
			end
			beats_out++;
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_res.size());
			$display("complex_arithmetic_unit regression: fail");
			$finish;
		end
	end

	task automatic send_beat(logic [1:0] op, logic [cau_pkg::DATA_WIDTH-1:0] a_re,
			logic [cau_pkg::DATA_WIDTH-1:0] a_im, logic [cau_pkg::DATA_WIDTH-1:0] b_re,
			logic [cau_pkg::DATA_WIDTH-1:0] b_im);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= cau_pkg::IN_TDATA_W'({b_im, b_re, a_im, a_re});
		do @(posedge clk); while (!s_tready);
		pending_res.push_back(alu_predict(op, a_re, a_im, b_re, b_im));
		beats_in++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	function automatic logic [cau_pkg::DATA_WIDTH-1:0] rand_part();
		case ($urandom_range(9))
			0, 1, 2, 3: return cau_pkg::DATA_WIDTH'($urandom);
			4, 5, 6: return cau_pkg::DATA_WIDTH'($urandom_range(0, 32'h001f_ffff)
				- 32'h0010_0000);
			default: begin
				case ($urandom_range(6))
					0: return '0;
					1: return cau_pkg::SAT_MAX;
					2: return cau_pkg::SAT_MIN;
					3: return cau_pkg::DATA_WIDTH'(1);
					4: return '1;
					5: return cau_pkg::DATA_WIDTH'(1) << cau_pkg::FRAC_BITS;
					default: return -(cau_pkg::DATA_WIDTH'(1) << cau_pkg::FRAC_BITS);
				endcase
			end
		endcase
	endfunction

	task automatic test_directed;
		logic [cau_pkg::DATA_WIDTH-1:0] one;
		logic [cau_pkg::DATA_WIDTH-1:0] mx;
		logic [cau_pkg::DATA_WIDTH-1:0] mn;
		logic [cau_pkg::DATA_WIDTH-1:0] lsb;
		one = cau_pkg::DATA_WIDTH'(1) << cau_pkg::FRAC_BITS;
		mx  = cau_pkg::SAT_MAX;
		mn  = cau_pkg::SAT_MIN;
		lsb = cau_pkg::DATA_WIDTH'(1);
		send_beat(cau_pkg::OP_ADD, mx, mn, mx, mn);             // both parts clamp
		send_beat(cau_pkg::OP_ADD, mx, mn, mn, mx);             // no clamp
		send_beat(cau_pkg::OP_SUB, mn, mx, mx, mn);
		send_beat(cau_pkg::OP_SUB, '0, '0, mn, mn);             // negating the minimum
		send_beat(cau_pkg::OP_MUL, mn, mn, mn, mn);
		send_beat(cau_pkg::OP_MUL, mx, '0, mx, '0);
		send_beat(cau_pkg::OP_MUL, '1, '0, lsb, '0);            // truncate toward zero
		send_beat(cau_pkg::OP_MUL, one, one, one, -one);
		send_beat(cau_pkg::OP_MUL, '0, mn, '0, mn);
		send_beat(cau_pkg::OP_DIV, one, one, '0, '0);           // zero divisor
		send_beat(cau_pkg::OP_DIV, mx, mn, '0, '0);
		send_beat(cau_pkg::OP_DIV, mx, mx, lsb, '0);            // huge quotient
		send_beat(cau_pkg::OP_DIV, mn, mn, '0, lsb);
		send_beat(cau_pkg::OP_DIV, one, '0, one, one);
		send_beat(cau_pkg::OP_DIV, -one, cau_pkg::DATA_WIDTH'(3), cau_pkg::DATA_WIDTH'(7),
			-one);
		send_beat(cau_pkg::OP_DIV, mn, mx, mn, mn);
		send_beat(cau_pkg::OP_DIV, '1, '1, mx, mx);             // tiny, rounds to zero
		send_beat(cau_pkg::OP_DIV, '0, '0, mn, '0);
		send_beat(cau_pkg::OP_ADD, '0, '0, '0, '0);
		send_beat(cau_pkg::OP_SUB, '1, '1, '1, '1);
		drain();
	endtask

	task automatic test_random(int beats, int idle, int stall);
		logic [1:0] op;
		logic [cau_pkg::DATA_WIDTH-1:0] br;
		logic [cau_pkg::DATA_WIDTH-1:0] bi;
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < beats; i++) begin
			op = 2'($urandom_range(3));
			br = rand_part();
			bi = rand_part();
			if (op == cau_pkg::OP_DIV && $urandom_range(19) == 0) begin
				br = '0;
				bi = '0;
			end
			send_beat(op, rand_part(), rand_part(), br, bi);
		end
		drain();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	// sender holds off until the pipe has fully emptied, then restarts
	task automatic test_pipe_drain_restart;
		for (int i = 0; i < 40; i++)
			send_beat(2'($urandom_range(3)), rand_part(), rand_part(), rand_part(), rand_part());
		drain();
		for (int i = 0; i < 40; i++)
			send_beat(2'($urandom_range(3)), rand_part(), rand_part(), rand_part(), rand_part());
		drain();
	endtask

	initial begin
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		div_zero_seen = 0;
		ovf_seen = 0;
		idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = cau_pkg::OP_ADD;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(400, 0, 0);
		test_random(350, 65, 0);
		test_random(350, 0, 65);
		test_random(350, 20, 20);
		test_pipe_drain_restart();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d beats in, %0d results out, %0d zero divisors, %0d saturations",
			beats_in, beats_out, div_zero_seen, ovf_seen);
		$display("phases: back-to-back, sender gaps, receiver stalls, both, drain and restart");
		if (errors == 0 && pending_res.size() == 0) begin
			$display("complex_arithmetic_unit regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_res.size());
			$display("complex_arithmetic_unit regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/complex_arithmetic_unit.sv
tb/tb_complex_arithmetic_unit.sv
